/* rtl/core/cnp_pkg.sv */
`default_nettype none
package cnp_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_ENTRIES  = 16384;

   localparam int VIDX_W = $clog2(MAX_VERTICES);      // vertex index
   localparam int VCNT_W = $clog2(MAX_VERTICES + 1);  // vertex count
   localparam int EIDX_W = $clog2(MAX_ENTRIES);       // list entry index
   localparam int ECNT_W = $clog2(MAX_ENTRIES + 1);   // entry count
   localparam int VAL_W  = 15;                        // degrees and core values

   localparam logic [2:0] ACT_CLEAR  = 3'd0;
   localparam logic [2:0] ACT_OPEN   = 3'd1;
   localparam logic [2:0] ACT_APPEND = 3'd2;
   localparam logic [2:0] ACT_RUN    = 3'd3;
   localparam logic [2:0] ACT_READ   = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_BADIDX = 2'd2;

   typedef struct packed {
      logic              start_we;
      logic [VIDX_W-1:0] start_waddr;
      logic [ECNT_W-1:0] start_wdata;
      logic [VIDX_W-1:0] start_raddr;
      logic              nbr_we;
      logic [EIDX_W-1:0] nbr_waddr;
      logic [VIDX_W-1:0] nbr_wdata;
      logic [EIDX_W-1:0] nbr_raddr;
      logic              deg_we;
      logic [VIDX_W-1:0] deg_waddr;
      logic [VAL_W-1:0]  deg_wdata;
      logic [VIDX_W-1:0] deg_raddr;
      logic              pk_we;
      logic [VIDX_W-1:0] pk_waddr;
      logic              pk_wdata;
      logic [VIDX_W-1:0] pk_raddr;
      logic              core_we;
      logic [VIDX_W-1:0] core_waddr;
      logic [VAL_W-1:0]  core_wdata;
      logic [VIDX_W-1:0] core_raddr;
   } mem_req_type;

   typedef struct packed {
      logic [ECNT_W-1:0] start_q;
      logic [VIDX_W-1:0] nbr_q;
      logic [VAL_W-1:0]  deg_q;
      logic              pk_q;
      logic [VAL_W-1:0]  core_q;
   } mem_rsp_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        status;
      logic [VAL_W-1:0]  value;
      logic [VCNT_W-1:0] vertex_total;
   } res_type;

endpackage
`default_nettype wire

/* rtl/core/core_number_peeling.sv */
`default_nettype none
// Core-number peeling over a graph loaded as adjacency lists.
// req channel: one item per command (clear, open vertex, append neighbor,
//   run, read core). rsp channel: exactly one item per req item, in order,
//   carrying status, value and the current vertex count.
// Command flow:
//   clear, open, append and reads out of range: result registered in the
//   cycle after accept, one item per cycle while rsp is taken.
//   read: one registered read of the core store, then the result.
//   run: index check of every list entry and degree setup, then for
//   each of the V rounds a min-degree scan and peel plus, per list
//   entry of the peeled vertex, neighbor read, degree read and degree
//   write back, then a closing scan and the result. The degree store
//   has a single read port, so the scan reads one vertex at a time.
// Reset clears vertex and entry counts and the control state; the stores
//   hold whatever they held and no value read from them is used before it is written.
// A stalled rsp holds its item in the output register; the next req item
//   is taken once the sequencer is idle and that register is taken or empty.
module core_number_peeling (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // action[2:0], neighbor[12:3], vertex[22:13]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata   // status[1:0], value[16:2], vertex_total[27:17]
);
   import cnp_pkg::*;

   logic        seq_idle;
   logic        item_accept;
   res_type     res;
   mem_req_type mreq;
   mem_rsp_type mrsp;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   // output register frees the input side when it is empty or being taken
   assign req_tready  = seq_idle && (!rsp_valid_ff || rsp_tready);
   assign item_accept = req_tvalid && req_tready;

   cnp_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .item_accept   (item_accept),
      .item_action   (req_tdata[2:0]),
      .item_neighbor (req_tdata[12:3]),
      .item_vertex   (req_tdata[22:13]),
      .idle          (seq_idle),
      .res           (res),
      .mreq          (mreq),
      .mrsp          (mrsp)
   );

   cnp_mem u_mem (
      .clock (clock),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res.valid) begin
         rsp_data_ff <= {4'b0, res.vertex_total, res.value, res.status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result overwrote a pending item");

   // a refused run reports zero
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == ST_BADIDX) |-> rsp_tdata[16:2] == '0)
      else $error("refused run with nonzero value");

   // vertex count never exceeds capacity
   a_vc_range: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> res.vertex_total <= VCNT_W'(MAX_VERTICES))
      else $error("vertex count out of range");

   // no item is taken while a run or read is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (!seq_idle) |-> !req_tready)
      else $error("ready while busy");

endmodule
`default_nettype wire

/* rtl/core/cnp_mem.sv */
`default_nettype none
module cnp_mem (
   input  wire logic                clock,
   input  wire cnp_pkg::mem_req_type mreq,
   output cnp_pkg::mem_rsp_type     mrsp
);
   import cnp_pkg::*;

   logic [ECNT_W-1:0] start_mem [MAX_VERTICES];
   logic [VIDX_W-1:0] nbr_mem   [MAX_ENTRIES];
   logic [VAL_W-1:0]  deg_mem   [MAX_VERTICES];
   logic              pk_mem    [MAX_VERTICES];
   logic [VAL_W-1:0]  core_mem  [MAX_VERTICES];

   // one write and one registered read port per store
   always_ff @(posedge clock) begin
      if (mreq.start_we) start_mem[mreq.start_waddr] <= mreq.start_wdata;
      if (mreq.nbr_we)   nbr_mem[mreq.nbr_waddr]     <= mreq.nbr_wdata;
      if (mreq.deg_we)   deg_mem[mreq.deg_waddr]     <= mreq.deg_wdata;
      if (mreq.pk_we)    pk_mem[mreq.pk_waddr]       <= mreq.pk_wdata;
      if (mreq.core_we)  core_mem[mreq.core_waddr]   <= mreq.core_wdata;
      mrsp.start_q <= start_mem[mreq.start_raddr];
      mrsp.nbr_q   <= nbr_mem[mreq.nbr_raddr];
      mrsp.deg_q   <= deg_mem[mreq.deg_raddr];
      mrsp.pk_q    <= pk_mem[mreq.pk_raddr];
      mrsp.core_q  <= core_mem[mreq.core_raddr];
   end

endmodule
`default_nettype wire

/* rtl/core/cnp_seq.sv */
`default_nettype none
module cnp_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_accept,
   input  wire logic [2:0]          item_action,
   input  wire logic [cnp_pkg::VIDX_W-1:0] item_neighbor,
   input  wire logic [cnp_pkg::VIDX_W-1:0] item_vertex,
   output logic                     idle,
   output cnp_pkg::res_type         res,
   output cnp_pkg::mem_req_type     mreq,
   input  wire cnp_pkg::mem_rsp_type mrsp
);
   import cnp_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_READ      = 4'd1;
   localparam logic [3:0] S_CHK       = 4'd2;
   localparam logic [3:0] S_INIT      = 4'd3;
   localparam logic [3:0] S_INIT_LAST = 4'd4;
   localparam logic [3:0] S_SCAN      = 4'd5;
   localparam logic [3:0] S_PEEL      = 4'd6;
   localparam logic [3:0] S_PEEL2     = 4'd7;
   localparam logic [3:0] S_PEEL3     = 4'd8;
   localparam logic [3:0] S_EDGE_A    = 4'd9;
   localparam logic [3:0] S_EDGE_B    = 4'd10;
   localparam logic [3:0] S_EDGE_C    = 4'd11;
   localparam logic [3:0] S_DONE      = 4'd12;

   logic [3:0]        state_ff, state_in;
   logic [VCNT_W-1:0] vc_ff, vc_in;
   logic [ECNT_W-1:0] ec_ff, ec_in;
   logic [VAL_W-1:0]  rc_ff, rc_in;
   logic [ECNT_W-1:0] cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [VIDX_W-1:0] pidx_ff, pidx_in;
   logic [ECNT_W-1:0] prev_ff, prev_in;
   logic              bad_ff, bad_in;
   logic              found_ff, found_in;
   logic [VIDX_W-1:0] best_ff, best_in;
   logic [VAL_W-1:0]  bestd_ff, bestd_in;
   logic [ECNT_W-1:0] e_ff, e_in;
   logic [ECNT_W-1:0] end_ff, end_in;
   logic [VIDX_W-1:0] n_ff, n_in;
   logic [VAL_W-1:0]  rc_new;

   assign idle = (state_ff == S_IDLE);
   assign rc_new = (bestd_ff > rc_ff) ? bestd_ff : rc_ff;

   always_comb begin
      state_in = state_ff;
      vc_in    = vc_ff;
      ec_in    = ec_ff;
      rc_in    = rc_ff;
      cnt_in   = cnt_ff;
      pend_in  = 1'b0;
      pidx_in  = pidx_ff;
      prev_in  = prev_ff;
      bad_in   = bad_ff;
      found_in = found_ff;
      best_in  = best_ff;
      bestd_in = bestd_ff;
      e_in     = e_ff;
      end_in   = end_ff;
      n_in     = n_ff;
      mreq     = '0;
      res      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (item_accept) begin
               res.valid  = 1'b1;
               res.status = ST_OK;
               case (item_action)
                  ACT_CLEAR: begin
                     vc_in = '0;
                     ec_in = '0;
                     rc_in = VAL_W'(1);
                  end
                  ACT_OPEN: begin
                     if (vc_ff == VCNT_W'(MAX_VERTICES)) begin
                        res.status = ST_FULL;
                     end else begin
                        mreq.start_we    = 1'b1;
                        mreq.start_waddr = vc_ff[VIDX_W-1:0];
                        mreq.start_wdata = ec_ff;
                        mreq.core_we     = 1'b1;
                        mreq.core_waddr  = vc_ff[VIDX_W-1:0];
                        vc_in = vc_ff + 1'b1;
                     end
                  end
                  ACT_APPEND: begin
                     // a 10-bit index is always below the vertex capacity
                     if (vc_ff == '0 || ec_ff == ECNT_W'(MAX_ENTRIES)) begin
                        res.status = ST_FULL;
                     end else begin
                        mreq.nbr_we    = 1'b1;
                        mreq.nbr_waddr = ec_ff[EIDX_W-1:0];
                        mreq.nbr_wdata = item_neighbor;
                        ec_in = ec_ff + 1'b1;
                     end
                  end
                  ACT_RUN: begin
                     res.valid = 1'b0;
                     cnt_in    = '0;
                     bad_in    = 1'b0;
                     state_in  = S_CHK;
                  end
                  ACT_READ: begin
                     if (VCNT_W'(item_vertex) >= vc_ff) begin
                        res.status = ST_FULL;
                     end else begin
                        res.valid       = 1'b0;
                        mreq.core_raddr = item_vertex;
                        state_in        = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            res.valid  = 1'b1;
            res.status = ST_OK;
            res.value  = mrsp.core_q;
            state_in   = S_IDLE;
         end
         S_CHK: begin
            // one stored index issued per cycle, checked in the next cycle when its read returns
            if (cnt_ff < ec_ff) begin
               mreq.nbr_raddr = cnt_ff[EIDX_W-1:0];
               cnt_in  = cnt_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff && VCNT_W'(mrsp.nbr_q) >= vc_ff) bad_in = 1'b1;
            if (cnt_ff >= ec_ff && !pend_ff) begin
               if (bad_ff) begin
                  res.valid  = 1'b1;
                  res.status = ST_BADIDX;
                  state_in   = S_IDLE;
               end else begin
                  cnt_in   = '0;
                  rc_in    = VAL_W'(1);
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            // degree of v is start[v+1] - start[v], entry count for the last; marks cleared on the way
            if (cnt_ff < ECNT_W'(vc_ff)) begin
               mreq.start_raddr = cnt_ff[VIDX_W-1:0];
               mreq.pk_we       = 1'b1;
               mreq.pk_waddr    = cnt_ff[VIDX_W-1:0];
               cnt_in  = cnt_ff + 1'b1;
               pend_in = 1'b1;
               pidx_in = cnt_ff[VIDX_W-1:0];
            end
            if (pend_ff) begin
               prev_in = mrsp.start_q;
               if (pidx_ff != '0) begin
                  mreq.deg_we    = 1'b1;
                  mreq.deg_waddr = VIDX_W'(pidx_ff - 1'b1);
                  mreq.deg_wdata = VAL_W'(mrsp.start_q - prev_ff);
               end
            end
            if (cnt_ff >= ECNT_W'(vc_ff) && !pend_ff) state_in = S_INIT_LAST;
         end
         S_INIT_LAST: begin
            if (vc_ff != '0) begin
               mreq.deg_we    = 1'b1;
               mreq.deg_waddr = VIDX_W'(vc_ff - 1'b1);
               mreq.deg_wdata = VAL_W'(ec_ff - prev_ff);
            end
            cnt_in   = '0;
            found_in = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // least live degree among unpeeled; strict less keeps lower index
            if (cnt_ff < ECNT_W'(vc_ff)) begin
               mreq.deg_raddr = cnt_ff[VIDX_W-1:0];
               mreq.pk_raddr  = cnt_ff[VIDX_W-1:0];
               cnt_in  = cnt_ff + 1'b1;
               pend_in = 1'b1;
               pidx_in = cnt_ff[VIDX_W-1:0];
            end
            if (pend_ff && !mrsp.pk_q && (!found_ff || mrsp.deg_q < bestd_ff)) begin
               best_in  = pidx_ff;
               bestd_in = mrsp.deg_q;
               found_in = 1'b1;
            end
            if (cnt_ff >= ECNT_W'(vc_ff) && !pend_ff) state_in = found_ff ? S_PEEL : S_DONE;
         end
         S_PEEL: begin
            rc_in            = rc_new;
            mreq.core_we     = 1'b1;
            mreq.core_waddr  = best_ff;
            mreq.core_wdata  = rc_new;
            mreq.pk_we       = 1'b1;
            mreq.pk_waddr    = best_ff;
            mreq.pk_wdata    = 1'b1;
            mreq.start_raddr = best_ff;
            state_in         = S_PEEL2;
         end
         S_PEEL2: begin
            e_in             = mrsp.start_q;
            mreq.start_raddr = VIDX_W'(best_ff + 1'b1);
            state_in         = S_PEEL3;
         end
         S_PEEL3: begin
            end_in   = ((VCNT_W'(best_ff) + 1'b1) < vc_ff) ? mrsp.start_q : ec_ff;
            state_in = S_EDGE_A;
         end
         S_EDGE_A: begin
            if (e_ff < end_ff) begin
               mreq.nbr_raddr = e_ff[EIDX_W-1:0];
               e_in     = e_ff + 1'b1;
               state_in = S_EDGE_B;
            end else begin
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_EDGE_B: begin
            mreq.deg_raddr = mrsp.nbr_q;
            mreq.pk_raddr  = mrsp.nbr_q;
            n_in     = mrsp.nbr_q;
            state_in = S_EDGE_C;
         end
         S_EDGE_C: begin
            // write lands before the next entry reads, so no forwarding needed
            if (!mrsp.pk_q && mrsp.deg_q != '0) begin
               mreq.deg_we    = 1'b1;
               mreq.deg_waddr = n_ff;
               mreq.deg_wdata = mrsp.deg_q - 1'b1;
            end
            state_in = S_EDGE_A;
         end
         S_DONE: begin
            res.valid  = 1'b1;
            res.status = ST_OK;
            res.value  = rc_ff;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      res.vertex_total = vc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vc_ff    <= '0;
         ec_ff    <= '0;
         rc_ff    <= VAL_W'(1);
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         vc_ff    <= vc_in;
         ec_ff    <= ec_in;
         rc_ff    <= rc_in;
         pend_ff  <= pend_in;
      end
      cnt_ff   <= cnt_in;
      pidx_ff  <= pidx_in;
      prev_ff  <= prev_in;
      bad_ff   <= bad_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bestd_ff <= bestd_in;
      e_ff     <= e_in;
      end_ff   <= end_in;
      n_ff     <= n_in;
   end

endmodule
`default_nettype wire
